[hw/rtl/sphere_pair_contact_macros.svh]
// assertion macros for the sphere pair contact checker
// expects clk and arst_n in the scope of each use
`ifndef SPHERE_PAIR_CONTACT_MACROS_SVH
`define SPHERE_PAIR_CONTACT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/spc_pkg.sv]
// shared constants for the sphere pair contact block
// no dependencies
package spc_pkg;
	localparam int COORD_BITS_DEF       = 24;
	localparam int NORMAL_FRAC_BITS_DEF = 14;
	localparam int SQ_BITS    = 64;  // normalised squared length word
	localparam int ROOT_BITS  = 32;  // root of the normalised word
	localparam int H_BITS     = 5;   // normalising shift, in bit pairs
	localparam int NORM_STEPS = 5;   // shift cells: 16, 8, 4, 2, 1 pairs
endpackage

[hw/rtl/spc_in_if.sv]
// input channel of the sphere pair contact block: one sphere pair per beat
// depends on spc_pkg
interface spc_in_if #(parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] first_z;
	logic        [COORD_BITS-3:0] first_radius;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic signed [COORD_BITS-1:0] second_z;
	logic        [COORD_BITS-3:0] second_radius;

	modport source (output valid, first_x, first_y, first_z, first_radius,
		second_x, second_y, second_z, second_radius, input ready);
	modport sink (input valid, first_x, first_y, first_z, first_radius,
		second_x, second_y, second_z, second_radius, output ready);
endinterface

[hw/rtl/spc_out_if.sv]
// output channel of the sphere pair contact block: one contact result per beat
// depends on spc_pkg
interface spc_out_if #(
	parameter int COORD_BITS       = spc_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = spc_pkg::NORMAL_FRAC_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic                               hit;
	logic        [COORD_BITS-2:0]       depth;
	logic signed [NORMAL_FRAC_BITS+1:0] normal_x;
	logic signed [NORMAL_FRAC_BITS+1:0] normal_y;
	logic signed [NORMAL_FRAC_BITS+1:0] normal_z;
	logic signed [COORD_BITS-1:0]       contact_a_x;
	logic signed [COORD_BITS-1:0]       contact_a_y;
	logic signed [COORD_BITS-1:0]       contact_a_z;
	logic signed [COORD_BITS-1:0]       contact_b_x;
	logic signed [COORD_BITS-1:0]       contact_b_y;
	logic signed [COORD_BITS-1:0]       contact_b_z;

	modport source (output valid, hit, depth, normal_x, normal_y, normal_z,
		contact_a_x, contact_a_y, contact_a_z, contact_b_x, contact_b_y, contact_b_z,
		input ready);
	modport sink (input valid, hit, depth, normal_x, normal_y, normal_z,
		contact_a_x, contact_a_y, contact_a_z, contact_b_x, contact_b_y, contact_b_z,
		output ready);
endinterface

[hw/rtl/sphere_pair_contact.sv]
// sphere pair contact: top level, front stages, cell chains and output skid
// depends on spc_pkg, spc_in_if, spc_out_if and the three cell modules
//
// Takes one sphere pair per cycle while pair.ready is high and returns one
// contact result per pair, in order, when the output side is ready. The
// pipeline holds the 32-cell square root chain and the NORMAL_FRAC_BITS+1
// divider cells per normal axis; every cell hands its partial result to its
// neighbour each cycle that the pipeline advances, so throughput stays one pair
// per cycle while the output is not stalled. Spheres that touch count as a hit.
// A miss returns all fields zero; coincident centres give a zero normal, depth
// equal to the radius sum and contact points at the centres. A two-entry output
// stage lets the chain keep moving while a result waits to be taken, until the skid entry fills.
module sphere_pair_contact #(
	parameter int COORD_BITS       = spc_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = spc_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	spc_in_if.sink  pair,
	spc_out_if.source contact
);
	import spc_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int F    = NORMAL_FRAC_BITS;
	localparam int RW   = C - 2;          // radius
	localparam int SW   = C - 1;          // radius sum, depth, in-range difference
	localparam int QW   = F + 1;          // normal magnitude
	localparam int NW   = F + 2;          // signed normal
	localparam int SQW  = 2 * C;          // squared length
	localparam int DIVW = ROOT_BITS + QW; // rounded dividend
	localparam int PW   = QW + RW;        // offset product
	localparam int SQRT_CELLS = ROOT_BITS;
	localparam int SB_SQRT0 = NORM_STEPS + 1;
	localparam int SB_PREP  = SB_SQRT0 + SQRT_CELLS;
	localparam int L        = SB_PREP + 1 + QW;  // sideband stages from the sum
	localparam int NST      = 2 + L + 2;         // all pipeline stages

	typedef struct packed {
		logic [2:0][C-1:0]  a;
		logic [2:0][C-1:0]  b;
		logic [RW-1:0]      ra;
		logic [RW-1:0]      rb;
		logic [SW-1:0]      rsum;
		logic [2:0][SW-1:0] ad;
		logic [2:0]         neg;
		logic               hit;
		logic               zero;
		logic [H_BITS-1:0]  h;
		logic [SW-1:0]      depth;
	} side_t;

	typedef struct packed {
		logic               hit;
		logic [SW-1:0]      depth;
		logic [2:0][NW-1:0] n;
		logic [2:0][C-1:0]  ca;
		logic [2:0][C-1:0]  cb;
	} res_t;

	// clamp a widened coordinate back into the signed coordinate range
	function automatic logic [C-1:0] sat(input logic signed [C+1:0] v);
		logic signed [C+1:0] hi;
		logic signed [C+1:0] lo;
		hi = (C+2)'((64'sd1 <<< (C-1)) - 64'sd1);
		lo = -hi - (C+2)'(1);
		if (v > hi) return hi[C-1:0];
		if (v < lo) return lo[C-1:0];
		return v[C-1:0];
	endfunction

	// handshake and global advance
	logic [NST-1:0] vld_q;
	logic           ov_q, sk_q;
	logic           go;
	res_t           o_q, skd_q;

	assign go         = !sk_q;
	assign pair.ready = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (go) begin
			vld_q <= {vld_q[NST-2:0], pair.valid};
		end
	end

	// stage 1: centre differences and radius sum
	logic [2:0][C-1:0] a_in, b_in;
	logic [2:0][C-1:0] a_s1, b_s1;
	logic [RW-1:0]     ra_s1, rb_s1;
	logic [SW-1:0]     rsum_s1;
	logic [2:0][C:0]   ad_s1;
	logic [2:0]        neg_s1;
	logic signed [C:0] d [3];
	logic [2:0][C:0]   ad_c;
	logic [SW-1:0]     rsum_c;

	assign a_in = {pair.first_z, pair.first_y, pair.first_x};
	assign b_in = {pair.second_z, pair.second_y, pair.second_x};

	always_comb begin
		rsum_c = SW'(pair.first_radius) + SW'(pair.second_radius);
		for (int i = 0; i < 3; i++) begin
			d[i]    = $signed({b_in[i][C-1], b_in[i]}) - $signed({a_in[i][C-1], a_in[i]});
			ad_c[i] = d[i][C] ? (C+1)'(-d[i]) : (C+1)'(d[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_s1    <= a_in;
			b_s1    <= b_in;
			ra_s1   <= pair.first_radius;
			rb_s1   <= pair.second_radius;
			rsum_s1 <= rsum_c;
			ad_s1   <= ad_c;
			for (int i = 0; i < 3; i++) neg_s1[i] <= d[i][C];
		end
	end

	// stage 2: squares; an axis beyond the radius sum already rules out a hit
	logic [2:0][C-1:0]      a_s2, b_s2;
	logic [RW-1:0]          ra_s2, rb_s2;
	logic [SW-1:0]          rsum_s2;
	logic [2:0][SW-1:0]     ad_s2;
	logic [2:0]             neg_s2;
	logic                   far_s2;
	logic [2:0][2*SW-1:0]   sqa_s2;
	logic [2*SW-1:0]        rr_s2;

	always_ff @(posedge clk) begin
		if (go) begin
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			ra_s2   <= ra_s1;
			rb_s2   <= rb_s1;
			rsum_s2 <= rsum_s1;
			neg_s2  <= neg_s1;
			far_s2  <= (ad_s1[0] > (C+1)'(rsum_s1)) || (ad_s1[1] > (C+1)'(rsum_s1))
				|| (ad_s1[2] > (C+1)'(rsum_s1));
			rr_s2   <= (2*SW)'(rsum_s1) * (2*SW)'(rsum_s1);
			for (int i = 0; i < 3; i++) begin
				ad_s2[i]  <= ad_s1[i][SW-1:0];
				sqa_s2[i] <= (2*SW)'(ad_s1[i][SW-1:0]) * (2*SW)'(ad_s1[i][SW-1:0]);
			end
		end
	end

	// stage 3: squared length and the hit decision, start of the sideband line
	side_t          sb [L];
	logic [SQW-1:0] sq_c;
	logic [SQ_BITS-1:0] word_s3;

	assign sq_c = SQW'(sqa_s2[0]) + SQW'(sqa_s2[1]) + SQW'(sqa_s2[2]);

	// prep stage values
	logic [SQ_BITS-1:0]   nw [NORM_STEPS+1];
	logic [H_BITS-1:0]    nh [NORM_STEPS+1];
	logic [SQ_BITS-1:0]   sw [SQRT_CELLS+1];
	logic [ROOT_BITS+1:0] sr [SQRT_CELLS+1];
	logic [ROOT_BITS-1:0] sq_root [SQRT_CELLS+1];
	logic [SW-1:0]        depth_c;
	side_t                sb_sqrt0_c;
	side_t                sb_prep_c;

	assign depth_c = sb[SB_PREP-1].rsum
		- SW'(sq_root[SQRT_CELLS] >> sb[SB_PREP-1].h);

	// sideband entries that pick up the shift count and the depth on the way
	always_comb begin
		sb_sqrt0_c       = sb[SB_SQRT0-1];
		sb_sqrt0_c.h     = nh[NORM_STEPS];
		sb_prep_c        = sb[SB_PREP-1];
		sb_prep_c.depth  = depth_c;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sb[0].a     <= a_s2;
			sb[0].b     <= b_s2;
			sb[0].ra    <= ra_s2;
			sb[0].rb    <= rb_s2;
			sb[0].rsum  <= rsum_s2;
			sb[0].ad    <= ad_s2;
			sb[0].neg   <= neg_s2;
			sb[0].hit   <= !far_s2 && (sq_c <= SQW'(rr_s2));
			sb[0].zero  <= (sq_c == '0);
			sb[0].h     <= '0;
			sb[0].depth <= '0;
			word_s3     <= SQ_BITS'(sq_c);
			for (int k = 1; k < L; k++) begin
				if (k == SB_SQRT0) sb[k] <= sb_sqrt0_c;
				else if (k == SB_PREP) sb[k] <= sb_prep_c;
				else sb[k] <= sb[k-1];
			end
		end
	end

	// normalising shift chain: largest pair shift that keeps the word in 64 bits
	assign nw[0] = word_s3;
	assign nh[0] = '0;

	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		spc_norm_cell #(.PAIRS(1 << (NORM_STEPS - 1 - k))) u_cell (
			.clk    (clk),
			.en     (go),
			.word_i (nw[k]),
			.h_i    (nh[k]),
			.word_o (nw[k+1]),
			.h_o    (nh[k+1])
		);
	end

	// square root chain, one root bit per cell
	assign sw[0]      = nw[NORM_STEPS];
	assign sr[0]      = '0;
	assign sq_root[0] = '0;

	for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
		spc_sqrt_cell u_cell (
			.clk    (clk),
			.en     (go),
			.word_i (sw[j]),
			.rem_i  (sr[j]),
			.root_i (sq_root[j]),
			.word_o (sw[j+1]),
			.rem_o  (sr[j+1]),
			.root_o (sq_root[j+1])
		);
	end

	// prep stage and divider lanes, one lane per axis
	logic [ROOT_BITS-1:0] dden [3][QW+1];
	logic [ROOT_BITS-1:0] drem [3][QW+1];
	logic [QW-1:0]        dlow [3][QW+1];
	logic [QW-1:0]        dquo [3][QW+1];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [ROOT_BITS-1:0] shv;
		logic [DIVW-1:0]      num;

		// shifted difference stays below 2^32 whenever the pair is a hit
		always_comb begin
			shv = ROOT_BITS'(sb[SB_PREP-1].ad[l]) << sb[SB_PREP-1].h;
			num = (DIVW'(shv) << F) + DIVW'(sq_root[SQRT_CELLS] >> 1);
		end

		always_ff @(posedge clk) begin
			if (go) begin
				dden[l][0] <= sq_root[SQRT_CELLS];
				drem[l][0] <= num[DIVW-1:QW];
				dlow[l][0] <= num[QW-1:0];
				dquo[l][0] <= '0;
			end
		end

		for (genvar c = 0; c < QW; c++) begin : g_cell
			spc_div_cell #(.QW(QW)) u_cell (
				.clk   (clk),
				.en    (go),
				.den_i (dden[l][c]),
				.rem_i (drem[l][c]),
				.low_i (dlow[l][c]),
				.quo_i (dquo[l][c]),
				.den_o (dden[l][c+1]),
				.rem_o (drem[l][c+1]),
				.low_o (dlow[l][c+1]),
				.quo_o (dquo[l][c+1])
			);
		end
	end

	// offset multiply stage
	localparam logic [QW-1:0] LIM = QW'(1) << F;
	side_t              side_mul;
	logic [2:0][NW-1:0] n_mul;
	logic [2:0][PW-1:0] pa_mul, pb_mul;
	logic [2:0][QW-1:0] qsel;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sb[L-1].zero) qsel[i] = '0;
			else if (dquo[i][QW] > LIM) qsel[i] = LIM;
			else qsel[i] = dquo[i][QW];
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			side_mul <= sb[L-1];
			for (int i = 0; i < 3; i++) begin
				n_mul[i]  <= sb[L-1].neg[i] ? NW'(-NW'(qsel[i])) : NW'(qsel[i]);
				pa_mul[i] <= PW'(qsel[i]) * PW'(sb[L-1].ra);
				pb_mul[i] <= PW'(qsel[i]) * PW'(sb[L-1].rb);
			end
		end
	end

	// final stage: round the offsets, move off the centres, saturate
	res_t fin_s;
	res_t fin_c;
	logic [PW:0]         offa, offb;
	logic signed [C+1:0] sa, sbv;

	always_comb begin
		fin_c = '0;
		offa  = '0;
		offb  = '0;
		sa    = '0;
		sbv   = '0;
		if (side_mul.hit) begin
			fin_c.hit   = 1'b1;
			fin_c.depth = side_mul.depth;
			for (int i = 0; i < 3; i++) begin
				offa = ((PW+1)'(pa_mul[i]) + ((PW+1)'(1) << (F-1))) >> F;
				offb = ((PW+1)'(pb_mul[i]) + ((PW+1)'(1) << (F-1))) >> F;
				sa   = $signed({{2{side_mul.a[i][C-1]}}, side_mul.a[i]});
				sbv  = $signed({{2{side_mul.b[i][C-1]}}, side_mul.b[i]});
				if (side_mul.neg[i]) begin
					sa  = sa - $signed(offa[C+1:0]);
					sbv = sbv + $signed(offb[C+1:0]);
				end else begin
					sa  = sa + $signed(offa[C+1:0]);
					sbv = sbv - $signed(offb[C+1:0]);
				end
				fin_c.n[i]  = n_mul[i];
				fin_c.ca[i] = sat(sa);
				fin_c.cb[i] = sat(sbv);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) fin_s <= fin_c;
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sk_q <= 1'b0;
		end else if (!ov_q || contact.ready) begin
			if (sk_q) begin
				ov_q <= 1'b1;
				sk_q <= 1'b0;
			end else begin
				ov_q <= vld_q[NST-1];
			end
		end else if (vld_q[NST-1] && go) begin
			sk_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || contact.ready) begin
			o_q <= sk_q ? skd_q : fin_s;
		end else if (go) begin
			skd_q <= fin_s;
		end
	end

	assign contact.valid       = ov_q;
	assign contact.hit         = o_q.hit;
	assign contact.depth       = o_q.depth;
	assign contact.normal_x    = o_q.n[0];
	assign contact.normal_y    = o_q.n[1];
	assign contact.normal_z    = o_q.n[2];
	assign contact.contact_a_x = o_q.ca[0];
	assign contact.contact_a_y = o_q.ca[1];
	assign contact.contact_a_z = o_q.ca[2];
	assign contact.contact_b_x = o_q.cb[0];
	assign contact.contact_b_y = o_q.cb[1];
	assign contact.contact_b_z = o_q.cb[2];
endmodule

[hw/rtl/spc_norm_cell.sv]
// one step of the normalising shift: shifts by a fixed number of bit pairs
// when the top bits are clear; depends on spc_pkg
module spc_norm_cell #(parameter int PAIRS = 1) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [spc_pkg::SQ_BITS-1:0]   word_i,
	input  logic [spc_pkg::H_BITS-1:0]    h_i,
	output logic [spc_pkg::SQ_BITS-1:0]   word_o,
	output logic [spc_pkg::H_BITS-1:0]    h_o
);
	import spc_pkg::*;

	logic clear;
	assign clear = (word_i[SQ_BITS-1 -: 2*PAIRS] == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			word_o <= clear ? (word_i << (2*PAIRS)) : word_i;
			h_o    <= clear ? h_i + H_BITS'(PAIRS) : h_i;
		end
	end
endmodule

[hw/rtl/spc_sqrt_cell.sv]
// one digit of the integer square root: brings in two bits, settles one root bit
// depends on spc_pkg
module spc_sqrt_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [spc_pkg::SQ_BITS-1:0]   word_i,
	input  logic [spc_pkg::ROOT_BITS+1:0] rem_i,
	input  logic [spc_pkg::ROOT_BITS-1:0] root_i,
	output logic [spc_pkg::SQ_BITS-1:0]   word_o,
	output logic [spc_pkg::ROOT_BITS+1:0] rem_o,
	output logic [spc_pkg::ROOT_BITS-1:0] root_o
);
	import spc_pkg::*;

	logic [ROOT_BITS+3:0] part;
	logic [ROOT_BITS+3:0] trial;
	logic                 take;

	always_comb begin
		part  = {rem_i, word_i[SQ_BITS-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		take  = (part >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_o <= word_i << 2;
			rem_o  <= take ? (part[ROOT_BITS+1:0] - trial[ROOT_BITS+1:0])
				: part[ROOT_BITS+1:0];
			root_o <= {root_i[ROOT_BITS-2:0], take};
		end
	end
endmodule

[hw/rtl/spc_div_cell.sv]
// one bit of restoring division for a normal component
// depends on spc_pkg
module spc_div_cell #(parameter int QW = 15) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [spc_pkg::ROOT_BITS-1:0] den_i,
	input  logic [spc_pkg::ROOT_BITS-1:0] rem_i,
	input  logic [QW-1:0]                 low_i,
	input  logic [QW-1:0]                 quo_i,
	output logic [spc_pkg::ROOT_BITS-1:0] den_o,
	output logic [spc_pkg::ROOT_BITS-1:0] rem_o,
	output logic [QW-1:0]                 low_o,
	output logic [QW-1:0]                 quo_o
);
	import spc_pkg::*;

	logic [ROOT_BITS:0] part;
	logic               take;

	always_comb begin
		part = {rem_i, low_i[QW-1]};
		take = (part >= {1'b0, den_i});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			rem_o <= take ? ROOT_BITS'(part - {1'b0, den_i}) : part[ROOT_BITS-1:0];
			low_o <= low_i << 1;
			quo_o <= {quo_i[QW-2:0], take};
		end
	end
endmodule

[hw/rtl/spc_checker.sv]
// port-level checks for the sphere pair contact block, bound to the top level
// depends on spc_pkg and sphere_pair_contact_macros.svh
`include "sphere_pair_contact_macros.svh"

module spc_checker #(
	parameter int COORD_BITS       = spc_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = spc_pkg::NORMAL_FRAC_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               hit,
	input logic        [COORD_BITS-2:0]       depth,
	input logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
	input logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
	input logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
	input logic signed [COORD_BITS-1:0]       contact_a_x,
	input logic signed [COORD_BITS-1:0]       contact_b_x
);
	import spc_pkg::*;

	localparam logic signed [NORMAL_FRAC_BITS+1:0] LIM =
		(NORMAL_FRAC_BITS+2)'(1) << NORMAL_FRAC_BITS;

	// a waiting result stays offered
	`SPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// a miss carries zero depth, zero normal and zero x contact coordinates
	`SPC_ASSERT_IMP(a_miss_zero, out_valid && !hit, depth == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0 && contact_a_x == '0 && contact_b_x == '0, "miss with non-zero fields")

	// normal components stay within one
	`SPC_ASSERT_IMP(a_normal_range, out_valid && hit, normal_x <= LIM && normal_x >= -LIM && normal_y <= LIM && normal_y >= -LIM && normal_z <= LIM && normal_z >= -LIM, "normal component out of range")
endmodule

bind sphere_pair_contact spc_checker #(
	.COORD_BITS       (COORD_BITS),
	.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_spc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (contact.valid),
	.out_ready   (contact.ready),
	.hit         (contact.hit),
	.depth       (contact.depth),
	.normal_x    (contact.normal_x),
	.normal_y    (contact.normal_y),
	.normal_z    (contact.normal_z),
	.contact_a_x (contact.contact_a_x),
	.contact_b_x (contact.contact_b_x)
);

[dv/tb_sphere_pair_contact.sv]
// self-checking testbench for the sphere pair contact block
// depends on spc_pkg, spc_in_if, spc_out_if and sphere_pair_contact
// directed pairs, then random pairs, checked against typed rows or a local contact predictor
module tb_sphere_pair_contact;
	import spc_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int NF = NORMAL_FRAC_BITS_DEF;
	localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam longint RAD_MAX = (64'sd1 <<< (CB - 2)) - 1;
	localparam int N_RANDOM = 830;
	localparam int LATENCY = 45 + NF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;
	localparam int N_FIELDS = 11;

	typedef struct packed {
		logic signed [CB-1:0] first_x, first_y, first_z;
		logic        [CB-3:0] first_radius;
		logic signed [CB-1:0] second_x, second_y, second_z;
		logic        [CB-3:0] second_radius;
	} pair_t;

	typedef struct packed {
		logic                 hit;
		logic        [CB-2:0] depth;
		logic signed [NF+1:0] normal_x, normal_y, normal_z;
		logic signed [CB-1:0] contact_a_x, contact_a_y, contact_a_z;
		logic signed [CB-1:0] contact_b_x, contact_b_y, contact_b_z;
	} contact_t;

	typedef struct {
		pair_t    pair;
		bit       typed;  // expected result given in the row
		contact_t want;
	} row_t;

	logic clk;
	logic arst_n;

	spc_in_if  #(.COORD_BITS(CB)) pair_ch ();
	spc_out_if #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(NF)) contact_ch ();

	sphere_pair_contact #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(NF)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pair    (pair_ch.sink),
		.contact (contact_ch.source)
	);

	contact_t pending_contacts[$];
	int       mismatches;
	int       pairs_taken;
	int       hold_left;
	bit       hold_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// integer square root, bit pair by bit pair
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// normal component times radius, back to Q12.12, ties away from zero
	function automatic longint radial_offset(longint n, longint unsigned r);
		longint unsigned mag;
		longint unsigned q;
		mag = (n < 0) ? longint'(-n) : longint'(n);
		q = (mag * r + (64'd1 << (NF - 1))) >> NF;
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic contact_t predict_contact(pair_t p);
		longint          ca[3], cb[3], nrm[3];
		longint unsigned ad[3];
		bit              neg[3];
		longint unsigned ra, rb, rsum, sq, len, num, q, lim;
		bit              touching;
		int              h;
		contact_t        c;
		ca[0] = p.first_x;  ca[1] = p.first_y;  ca[2] = p.first_z;
		cb[0] = p.second_x; cb[1] = p.second_y; cb[2] = p.second_z;
		ra = p.first_radius;
		rb = p.second_radius;
		rsum = ra + rb;
		touching = 1'b1;
		sq = 0;
		lim = 64'd1 << NF;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cb[i] < ca[i];
			ad[i] = neg[i] ? longint'(ca[i] - cb[i]) : longint'(cb[i] - ca[i]);
			nrm[i] = 0;
			if (ad[i] > rsum)
				touching = 1'b0;
		end
		c = '0;
		// far apart on one axis: no squares needed
		if (touching) begin
			sq = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
			if (sq > rsum * rsum)
				touching = 1'b0;
		end
		if (!touching)
			return c;
		c.hit = 1'b1;
		c.depth = (CB-1)'(rsum - root_floor(sq));
		// coincident centres leave the normal at zero
		if (sq != 0) begin
			h = 0;
			while (h < 31 && (sq >> (62 - 2 * h)) == 0)
				h++;
			len = root_floor(sq << (2 * h));
			for (int i = 0; i < 3; i++) begin
				num = (ad[i] << h) << NF;
				q = (num + (len >> 1)) / len;
				if (q > lim)
					q = lim;
				nrm[i] = neg[i] ? -longint'(q) : longint'(q);
			end
		end
		c.normal_x = (NF+2)'(nrm[0]);
		c.normal_y = (NF+2)'(nrm[1]);
		c.normal_z = (NF+2)'(nrm[2]);
		c.contact_a_x = CB'(clamp_coord(ca[0] + radial_offset(nrm[0], ra)));
		c.contact_a_y = CB'(clamp_coord(ca[1] + radial_offset(nrm[1], ra)));
		c.contact_a_z = CB'(clamp_coord(ca[2] + radial_offset(nrm[2], ra)));
		c.contact_b_x = CB'(clamp_coord(cb[0] - radial_offset(nrm[0], rb)));
		c.contact_b_y = CB'(clamp_coord(cb[1] - radial_offset(nrm[1], rb)));
		c.contact_b_z = CB'(clamp_coord(cb[2] - radial_offset(nrm[2], rb)));
		return c;
	endfunction

	function automatic pair_t make_pair(longint fx, longint fy, longint fz, longint fr,
		longint sx, longint sy, longint sz, longint sr);
		pair_t p;
		p.first_x = CB'(fx); p.first_y = CB'(fy); p.first_z = CB'(fz);
		p.first_radius = (CB-2)'(fr);
		p.second_x = CB'(sx); p.second_y = CB'(sy); p.second_z = CB'(sz);
		p.second_radius = (CB-2)'(sr);
		return p;
	endfunction

	function automatic contact_t make_contact(bit hit, longint depth, longint nx, longint ny,
		longint nz, longint ax, longint ay, longint az, longint bx, longint by, longint bz);
		contact_t c;
		c.hit = hit; c.depth = (CB-1)'(depth);
		c.normal_x = (NF+2)'(nx); c.normal_y = (NF+2)'(ny); c.normal_z = (NF+2)'(nz);
		c.contact_a_x = CB'(ax); c.contact_a_y = CB'(ay); c.contact_a_z = CB'(az);
		c.contact_b_x = CB'(bx); c.contact_b_y = CB'(by); c.contact_b_z = CB'(bz);
		return c;
	endfunction

	function automatic longint rand_coord();
		return longint'($signed(CB'($urandom)));
	endfunction

	// random pair: mostly near misses and overlaps, some wholly random bits
	function automatic pair_t random_pair();
		pair_t        p;
		logic [191:0] raw;
		longint       f[3], s[3], ra, rb, span;
		int           mode;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			p = raw[$bits(pair_t)-1:0];
			return p;
		end
		ra = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, RAD_MAX))
			: longint'($urandom_range(0, 20000));
		rb = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, RAD_MAX))
			: longint'($urandom_range(0, 20000));
		span = ra + rb + 8;
		for (int i = 0; i < 3; i++) begin
			f[i] = rand_coord();
			if (mode == 2)
				s[i] = f[i];  // coincident centres
			else
				s[i] = clamp_coord(f[i] + longint'($urandom_range(0, 2 * span)) - span);
		end
		return make_pair(f[0], f[1], f[2], ra, s[0], s[1], s[2], rb);
	endfunction

	row_t stim_rows[$];

	initial begin
		// well apart
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, 40960, 0, 0, 4096), 1'b1,
			make_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		// coincident centres, zero radii
		stim_rows.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			make_contact(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		// touching on x counts as a hit
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, 8192, 0, 0, 4096), 1'b1,
			make_contact(1, 0, 16384, 0, 0, 4096, 0, 0, 4096, 0, 0)});
		// one step apart from touching
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, 8193, 0, 0, 4096), 1'b1,
			make_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		// coincident at the top corner, largest radii
		stim_rows.push_back('{make_pair(COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX), 1'b1,
			make_contact(1, 2 * RAD_MAX, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX)});
		// coincident at the bottom corner
		stim_rows.push_back('{make_pair(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX,
			COORD_MIN, COORD_MIN, COORD_MIN, 0), 1'b1,
			make_contact(1, RAD_MAX, 0, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN)});
		// opposite corners, far beyond any radius sum
		stim_rows.push_back('{make_pair(COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX), 1'b1,
			make_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		// touching on each negative axis, then overlaps on positive y and z
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, -8192, 0, 0, 4096), 1'b0, '0});
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, 0, -8192, 0, 4096), 1'b0, '0});
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, 0, 0, -8192, 4096), 1'b0, '0});
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, 0, 4096, 0, 4096), 1'b0, '0});
		stim_rows.push_back('{make_pair(0, 0, 0, 4096, 0, 0, 4096, 4096), 1'b0, '0});
		// contact points pushed past the coordinate range
		stim_rows.push_back('{make_pair(COORD_MAX - 600, 0, 0, RAD_MAX,
			COORD_MAX, 0, 0, RAD_MAX), 1'b0, '0});
		stim_rows.push_back('{make_pair(COORD_MIN + 600, 0, 0, RAD_MAX,
			COORD_MIN, 0, 0, RAD_MAX), 1'b0, '0});
		stim_rows.push_back('{make_pair(0, COORD_MIN, 0, RAD_MAX, 0, COORD_MIN + 5, 0,
			RAD_MAX), 1'b0, '0});
		// diagonal overlaps, unit step and tiny spheres
		stim_rows.push_back('{make_pair(1000, -2000, 3000, 9000, 4000, 1000, -1000, 7000),
			1'b0, '0});
		stim_rows.push_back('{make_pair(0, 0, 0, 1, 1, 0, 0, 0), 1'b0, '0});
		stim_rows.push_back('{make_pair(-1, -1, -1, 1, 0, 0, 0, 1), 1'b0, '0});
		stim_rows.push_back('{make_pair(5, 5, 5, RAD_MAX, -5, -5, -5, RAD_MAX), 1'b0, '0});
		// one axis beyond the radius sum, others zero
		stim_rows.push_back('{make_pair(0, 0, 0, RAD_MAX, 0, 0, 2 * RAD_MAX + 1, 0),
			1'b0, '0});
	end

	// sender: directed rows, then random pairs in bursts with gaps
	initial begin
		int     burst;
		int     total;
		pair_t  p;
		contact_t want;
		bit     typed;
		arst_n = 1'b0;
		pair_ch.valid = 1'b0;
		pair_ch.first_x = '0; pair_ch.first_y = '0; pair_ch.first_z = '0;
		pair_ch.first_radius = '0;
		pair_ch.second_x = '0; pair_ch.second_y = '0; pair_ch.second_z = '0;
		pair_ch.second_radius = '0;
		pairs_taken = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		total = stim_rows.size() + N_RANDOM;
		burst = $urandom_range(1, 30);
		for (int k = 0; k < total; k++) begin
			if (k < stim_rows.size()) begin
				p = stim_rows[k].pair;
				typed = stim_rows[k].typed;
				want = stim_rows[k].want;
			end else begin
				p = random_pair();
				typed = 1'b0;
			end
			if (!typed)
				want = predict_contact(p);
			pair_ch.valid <= 1'b1;
			pair_ch.first_x <= p.first_x; pair_ch.first_y <= p.first_y;
			pair_ch.first_z <= p.first_z; pair_ch.first_radius <= p.first_radius;
			pair_ch.second_x <= p.second_x; pair_ch.second_y <= p.second_y;
			pair_ch.second_z <= p.second_z; pair_ch.second_radius <= p.second_radius;
			// beat taken when valid and ready both seen high at an edge
			do @(posedge clk); while (!pair_ch.ready);
			pending_contacts.push_back(want);
			pairs_taken++;
			if (k == total / 2) begin
				// drain everything before going on
				pair_ch.valid <= 1'b0;
				while (pending_contacts.size() != 0)
					@(posedge clk);
			end else if (--burst == 0) begin
				burst = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0) begin
					pair_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end
		pair_ch.valid <= 1'b0;
		while (pending_contacts.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// receiver: stall pattern in phases, plus one long hold while the sender keeps going
	initial begin
		int phase_left;
		int stall_pct;
		contact_ch.ready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		phase_left = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (!hold_done && pairs_taken >= 150) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 80);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				contact_ch.ready <= 1'b0;
			end else begin
				contact_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// checker: each result beat against the oldest pending contact
	always @(posedge clk) begin
		contact_t got, want;
		logic [63:0] gv[N_FIELDS], wv[N_FIELDS];
		string names[N_FIELDS];
		bit bad;
		names = '{"hit", "depth", "normal_x", "normal_y", "normal_z", "contact_a_x",
			"contact_a_y", "contact_a_z", "contact_b_x", "contact_b_y", "contact_b_z"};
		if (arst_n && contact_ch.valid && contact_ch.ready) begin
			got = make_contact(contact_ch.hit, contact_ch.depth, contact_ch.normal_x,
				contact_ch.normal_y, contact_ch.normal_z, contact_ch.contact_a_x,
				contact_ch.contact_a_y, contact_ch.contact_a_z, contact_ch.contact_b_x,
				contact_ch.contact_b_y, contact_ch.contact_b_z);
			if (pending_contacts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", got);
			end else begin
				want = pending_contacts.pop_front();
				gv = '{got.hit, got.depth, got.normal_x, got.normal_y, got.normal_z,
					got.contact_a_x, got.contact_a_y, got.contact_a_z,
					got.contact_b_x, got.contact_b_y, got.contact_b_z};
				wv = '{want.hit, want.depth, want.normal_x, want.normal_y, want.normal_z,
					want.contact_a_x, want.contact_a_y, want.contact_a_z,
					want.contact_b_x, want.contact_b_y, want.contact_b_z};
				bad = 1'b0;
				for (int i = 0; i < N_FIELDS; i++)
					if (gv[i] !== wv[i]) begin
						if (!bad)
							mismatches++;
						bad = 1'b1;
						if (mismatches <= 10)
							$display("mismatch on %s: expected %h got %h", names[i],
								wv[i], gv[i]);
					end
			end
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/spc_pkg.sv
hw/rtl/spc_in_if.sv
hw/rtl/spc_out_if.sv
hw/rtl/spc_norm_cell.sv
hw/rtl/spc_sqrt_cell.sv
hw/rtl/spc_div_cell.sv
hw/rtl/sphere_pair_contact.sv
hw/rtl/spc_checker.sv
dv/tb_sphere_pair_contact.sv
